// ----- rtl/talc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// talc_pkg: shared types and constants of the tilted aperture loss check
// Word formats, configuration layout, result codes and datapath widths.
// ----------------------------------------------------------------------------
package talc_pkg;

    // Position word width (positions, offsets, half-sizes)
    localparam int POS_WIDTH = 32;

    // Datapath widths
    localparam int TRIG_W  = 18;                  // tilt cosine / sine, Q1.16
    localparam int DIF_W   = POS_WIDTH + 1;       // position minus offset
    localparam int PROD_W  = DIF_W + TRIG_W;      // one rotation product
    localparam int ROT_W   = PROD_W + 1;          // rotated coordinate
    localparam int MAG_W   = ROT_W;               // magnitude of rotated coordinate
    localparam int HALF_W  = POS_WIDTH - 1;       // magnitude of a positive half-size
    localparam int RUN_W   = DIF_W + 27;          // runaway compare width

    // Limb multiplier geometry
    localparam int LIMB_W  = 32;
    localparam int MUL_W   = MAG_W + HALF_W;      // widest multiplier operand
    localparam int NLIMB   = (MUL_W + LIMB_W - 1) / LIMB_W;
    localparam int LANE_W  = NLIMB * LIMB_W;
    localparam int ROW_W   = 2 * LANE_W;
    localparam int PROD2_W = 2 * MUL_W;
    localparam int MUL_LAT = 3;                   // partial products, rows, final sum
    localparam int CMP_W   = PROD2_W + 34;        // wide compare width

    // Front-to-back queue
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_COS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_SIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MOM  = 3'd7;

    localparam logic signed [TRIG_W-1:0] TILT_COS_RESET = 18'sd65536;

    // Aperture shapes (the unused code tests as a rectangle)
    localparam logic [1:0] SHAPE_RECT    = 2'd0;
    localparam logic [1:0] SHAPE_ELLIPSE = 2'd1;
    localparam logic [1:0] SHAPE_HYPER   = 2'd2;

    // Limits
    localparam logic [31:0]        RUNAWAY_LIMIT = 32'd65536000;  // 1000 cm, Q16.16
    localparam logic signed [31:0] DP_NEG_ONE    = -32'sd16777216; // -1.0, Q8.24

    // Result codes
    typedef enum logic [1:0] {
        ST_SURVIVED = 2'd0,
        ST_NEG_MOM  = 2'd1,
        ST_APERTURE = 2'd2,
        ST_RUNAWAY  = 2'd3
    } t_status;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_RUNAWAY = 2'd1;
    localparam logic [1:0] KIND_LOSS    = 2'd2;

    // Input word
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] momentum_dev;
        logic [15:0]        element_index;
        logic [31:0]        turn_number;
    } t_in;

    // Result word
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  loss_kind;
        logic [16:0] lost_element;
        logic [31:0] lost_turn;
    } t_out;

    // Configuration registers
    typedef struct packed {
        logic [31:0]              half_size_x;
        logic [31:0]              half_size_y;
        logic [1:0]               shape_mode;
        logic [31:0]              offset_x;
        logic [31:0]              offset_y;
        logic signed [TRIG_W-1:0] tilt_cosine;
        logic signed [TRIG_W-1:0] tilt_sine;
        logic [31:0]              reference_momentum;
    } t_cfg;

    // Classified word carried from front to back
    typedef struct packed {
        logic signed [DIF_W-1:0] dx;
        logic signed [DIF_W-1:0] dy;
        logic                    mom;     // negative total momentum
        logic                    ap_en;   // both half-sizes positive
        logic                    run;     // coordinate beyond 1000 cm
        logic [15:0]             element;
        logic [31:0]             turn;
    } t_item;

    // Read a 32-bit field as a POS_WIDTH-bit two's complement position
    function automatic logic signed [POS_WIDTH-1:0] pos_of(input logic [31:0] v);
        pos_of = POS_WIDTH'(v);
    endfunction

endpackage

// ----- rtl/talc_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// talc_mul: pipelined unsigned limb multiplier
// 32x32 partial products, per-limb rows, then one final row sum; three stages.
// ----------------------------------------------------------------------------
module talc_mul (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [talc_pkg::MUL_W-1:0]   i_a,
    input  logic [talc_pkg::MUL_W-1:0]   i_b,
    output logic [talc_pkg::PROD2_W-1:0] o_p
);

    logic [talc_pkg::LANE_W-1:0]   w_a;
    logic [talc_pkg::LANE_W-1:0]   w_b;
    logic [2*talc_pkg::LIMB_W-1:0] r_pp   [talc_pkg::NLIMB][talc_pkg::NLIMB];
    logic [talc_pkg::ROW_W-1:0]    n_even [talc_pkg::NLIMB];
    logic [talc_pkg::ROW_W-1:0]    n_odd  [talc_pkg::NLIMB];
    logic [talc_pkg::ROW_W-1:0]    n_row  [talc_pkg::NLIMB];
    logic [talc_pkg::ROW_W-1:0]    r_row  [talc_pkg::NLIMB];
    logic [talc_pkg::ROW_W-1:0]    n_sum;
    logic [talc_pkg::ROW_W-1:0]    r_sum;

    assign w_a = talc_pkg::LANE_W'(i_a);
    assign w_b = talc_pkg::LANE_W'(i_b);

    // Form all limb partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < talc_pkg::NLIMB; i++) begin
                for (int j = 0; j < talc_pkg::NLIMB; j++) begin
                    r_pp[i][j] <= w_a[i*talc_pkg::LIMB_W +: talc_pkg::LIMB_W]
                                * w_b[j*talc_pkg::LIMB_W +: talc_pkg::LIMB_W];
                end
            end
        end
    end

    // Pack even and odd partial products of each limb into two rows and add them
    always_comb begin
        for (int i = 0; i < talc_pkg::NLIMB; i++) begin
            n_even[i] = '0;
            n_odd[i]  = '0;
            for (int j = 0; j < talc_pkg::NLIMB; j++) begin
                if ((j % 2) == 0) begin
                    n_even[i] = n_even[i] | (talc_pkg::ROW_W'(r_pp[i][j])
                                << (talc_pkg::LIMB_W * (i + j)));
                end else begin
                    n_odd[i] = n_odd[i] | (talc_pkg::ROW_W'(r_pp[i][j])
                               << (talc_pkg::LIMB_W * (i + j)));
                end
            end
            n_row[i] = n_even[i] + n_odd[i];
        end
    end

    // Sum the limb rows
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < talc_pkg::NLIMB; i++) begin
            n_sum = n_sum + r_row[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
            r_sum <= n_sum;
        end
    end

    assign o_p = r_sum[talc_pkg::PROD2_W-1:0];

endmodule

// ----- rtl/talc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// talc_front: input stage of the loss check
// Takes particle words, classifies momentum, runaway and aperture enable,
// forms the offset position and pushes the result into the queue.
// ----------------------------------------------------------------------------
module talc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  talc_pkg::t_cfg   i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  talc_pkg::t_in    i_in,
    input  logic             i_full,
    output logic             o_push,
    output talc_pkg::t_item  o_item
);

    logic                              r_vld;
    talc_pkg::t_item                   r_item;
    talc_pkg::t_item                   n_item;
    logic                              w_accept;
    logic signed [talc_pkg::DIF_W-1:0] w_px;
    logic signed [talc_pkg::DIF_W-1:0] w_py;
    logic [talc_pkg::DIF_W-1:0]        w_mag_x;
    logic [talc_pkg::DIF_W-1:0]        w_mag_y;
    logic signed [talc_pkg::POS_WIDTH-1:0] w_hx;
    logic signed [talc_pkg::POS_WIDTH-1:0] w_hy;
    logic signed [31:0]                w_dp;

    // Stall only while the held word cannot enter the queue
    assign o_push     = r_vld && !i_full;
    assign o_in_stall = r_vld && i_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_item     = r_item;

    assign w_px = talc_pkg::DIF_W'(talc_pkg::pos_of(i_in.pos_x));
    assign w_py = talc_pkg::DIF_W'(talc_pkg::pos_of(i_in.pos_y));
    assign w_hx = talc_pkg::pos_of(i_cfg.half_size_x);
    assign w_hy = talc_pkg::pos_of(i_cfg.half_size_y);
    assign w_dp = i_in.momentum_dev;

    // Magnitudes for the runaway test
    assign w_mag_x = w_px[talc_pkg::DIF_W-1] ? -w_px : w_px;
    assign w_mag_y = w_py[talc_pkg::DIF_W-1] ? -w_py : w_py;

    // Classify the incoming word
    always_comb begin
        n_item.dx = w_px - talc_pkg::DIF_W'(talc_pkg::pos_of(i_cfg.offset_x));
        n_item.dy = w_py - talc_pkg::DIF_W'(talc_pkg::pos_of(i_cfg.offset_y));
        n_item.mom = (i_cfg.reference_momentum != '0) && (w_dp < talc_pkg::DP_NEG_ONE);
        n_item.ap_en = !w_hx[talc_pkg::POS_WIDTH-1] && (w_hx != '0)
                    && !w_hy[talc_pkg::POS_WIDTH-1] && (w_hy != '0);
        n_item.run = (talc_pkg::RUN_W'(w_mag_x) > talc_pkg::RUN_W'(talc_pkg::RUNAWAY_LIMIT))
                  || (talc_pkg::RUN_W'(w_mag_y) > talc_pkg::RUN_W'(talc_pkg::RUNAWAY_LIMIT));
        n_item.element = i_in.element_index;
        n_item.turn    = i_in.turn_number;
    end

    // Hold one classified word until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/talc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// talc_queue: short queue between front and back
// Register-based FIFO; the head word is visible while not empty.
// ----------------------------------------------------------------------------
module talc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  talc_pkg::t_item  i_item,
    input  logic             i_pop,
    output talc_pkg::t_item  o_item,
    output logic             o_full,
    output logic             o_empty
);

    talc_pkg::t_item             r_mem [talc_pkg::QDEPTH];
    logic [talc_pkg::QPTR_W-1:0] r_wp;
    logic [talc_pkg::QPTR_W-1:0] r_rp;
    logic [talc_pkg::QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (talc_pkg::QPTR_W + 1)'(talc_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ----- rtl/talc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// talc_back: aperture test pipeline and result register
// Rotates the offset position, runs the rectangle, hyperbola and ellipse
// tests exactly, then picks the loss code. Word stages hold on output stall.
// ----------------------------------------------------------------------------
module talc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  talc_pkg::t_cfg   i_cfg,
    input  talc_pkg::t_item  i_item,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output talc_pkg::t_out   o_out
);

    // Stage numbers of the tag line
    localparam int ST_MAG  = 3;
    localparam int ST_RECT = ST_MAG + 1;
    localparam int ST_L1   = ST_MAG + talc_pkg::MUL_LAT;
    localparam int ST_HYP  = ST_L1 + 2;
    localparam int ST_L2   = ST_L1 + talc_pkg::MUL_LAT;
    localparam int NST     = ST_L2 + 1;

    typedef struct packed {
        logic        mom;
        logic        ap_en;
        logic        run;
        logic        rect;
        logic        hyp;
        logic [15:0] element;
        logic [31:0] turn;
    } t_tag;

    logic                                 w_adv;
    logic [NST:1]                         r_vld;
    t_tag                                 r_tag [1:NST];
    t_tag                                 n_tag [1:NST];
    logic                                 r_out_vld;
    talc_pkg::t_out                       r_out;
    talc_pkg::t_out                       n_out;

    logic signed [talc_pkg::DIF_W-1:0]    w_dx;
    logic signed [talc_pkg::DIF_W-1:0]    w_dy;
    logic signed [talc_pkg::TRIG_W-1:0]   w_cos;
    logic signed [talc_pkg::TRIG_W-1:0]   w_sin;
    logic [talc_pkg::HALF_W-1:0]          w_sx;
    logic [talc_pkg::HALF_W-1:0]          w_sy;

    logic signed [talc_pkg::PROD_W-1:0]   r_xc;
    logic signed [talc_pkg::PROD_W-1:0]   r_ys;
    logic signed [talc_pkg::PROD_W-1:0]   r_yc;
    logic signed [talc_pkg::PROD_W-1:0]   r_xs;
    logic signed [talc_pkg::ROT_W-1:0]    r_xr;
    logic signed [talc_pkg::ROT_W-1:0]    r_yr;
    logic [talc_pkg::MAG_W-1:0]           r_ax;
    logic [talc_pkg::MAG_W-1:0]           r_ay;
    logic                                 w_rect;

    logic [talc_pkg::PROD2_W-1:0]         w_xx;
    logic [talc_pkg::PROD2_W-1:0]         w_yy;
    logic [talc_pkg::PROD2_W-1:0]         w_xy;
    logic [talc_pkg::PROD2_W-1:0]         w_a_p;
    logic [talc_pkg::PROD2_W-1:0]         w_b_p;
    logic [talc_pkg::PROD2_W-1:0]         w_aa;
    logic [talc_pkg::PROD2_W-1:0]         w_bb;
    logic [talc_pkg::PROD2_W-1:0]         w_sx2;
    logic [talc_pkg::PROD2_W-1:0]         w_sy2;
    logic [talc_pkg::PROD2_W-1:0]         w_c_p;
    logic [talc_pkg::PROD2_W-1:0]         w_c2;

    logic [talc_pkg::CMP_W-1:0]           r_hsum;
    logic [talc_pkg::CMP_W-1:0]           r_hxy2;
    logic [talc_pkg::CMP_W-1:0]           r_esum;
    logic                                 w_hyp;
    logic                                 w_ell;
    logic                                 w_outside;

    // Move the whole pipeline unless the result register is full and stalled
    assign w_adv       = !r_out_vld || !i_out_stall;
    assign o_pop       = w_adv && !i_empty;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign w_dx  = i_item.dx;
    assign w_dy  = i_item.dy;
    assign w_cos = i_cfg.tilt_cosine;
    assign w_sin = i_cfg.tilt_sine;
    assign w_sx  = talc_pkg::HALF_W'(talc_pkg::pos_of(i_cfg.half_size_x));
    assign w_sy  = talc_pkg::HALF_W'(talc_pkg::pos_of(i_cfg.half_size_y));

    // Rotation products
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xc <= talc_pkg::PROD_W'(w_dx) * talc_pkg::PROD_W'(w_cos);
            r_ys <= talc_pkg::PROD_W'(w_dy) * talc_pkg::PROD_W'(w_sin);
            r_yc <= talc_pkg::PROD_W'(w_dy) * talc_pkg::PROD_W'(w_cos);
            r_xs <= talc_pkg::PROD_W'(w_dx) * talc_pkg::PROD_W'(w_sin);
        end
    end

    // Rotated coordinates and their magnitudes
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xr <= talc_pkg::ROT_W'(r_xc) + talc_pkg::ROT_W'(r_ys);
            r_yr <= talc_pkg::ROT_W'(r_yc) - talc_pkg::ROT_W'(r_xs);
            r_ax <= talc_pkg::MAG_W'(r_xr[talc_pkg::ROT_W-1] ? -r_xr : r_xr);
            r_ay <= talc_pkg::MAG_W'(r_yr[talc_pkg::ROT_W-1] ? -r_yr : r_yr);
        end
    end

    // Rectangle test against half-sizes scaled to the rotated units
    assign w_rect = (r_ax > talc_pkg::MAG_W'({w_sx, 16'b0}))
                 || (r_ay > talc_pkg::MAG_W'({w_sy, 16'b0}));

    // First multiplier level: squares, cross product, scaled coordinates
    talc_mul u_mul_xx (.i_clk(i_clk), .i_en(w_adv),
        .i_a(talc_pkg::MUL_W'(r_ax)), .i_b(talc_pkg::MUL_W'(r_ax)), .o_p(w_xx));
    talc_mul u_mul_yy (.i_clk(i_clk), .i_en(w_adv),
        .i_a(talc_pkg::MUL_W'(r_ay)), .i_b(talc_pkg::MUL_W'(r_ay)), .o_p(w_yy));
    talc_mul u_mul_xy (.i_clk(i_clk), .i_en(w_adv),
        .i_a(talc_pkg::MUL_W'(r_ax)), .i_b(talc_pkg::MUL_W'(r_ay)), .o_p(w_xy));
    talc_mul u_mul_a (.i_clk(i_clk), .i_en(w_adv),
        .i_a(talc_pkg::MUL_W'(r_ax)), .i_b(talc_pkg::MUL_W'(w_sy)), .o_p(w_a_p));
    talc_mul u_mul_b (.i_clk(i_clk), .i_en(w_adv),
        .i_a(talc_pkg::MUL_W'(r_ay)), .i_b(talc_pkg::MUL_W'(w_sx)), .o_p(w_b_p));

    // Second multiplier level: ellipse terms
    talc_mul u_mul_aa (.i_clk(i_clk), .i_en(w_adv),
        .i_a(w_a_p[talc_pkg::MUL_W-1:0]), .i_b(w_a_p[talc_pkg::MUL_W-1:0]), .o_p(w_aa));
    talc_mul u_mul_bb (.i_clk(i_clk), .i_en(w_adv),
        .i_a(w_b_p[talc_pkg::MUL_W-1:0]), .i_b(w_b_p[talc_pkg::MUL_W-1:0]), .o_p(w_bb));

    // Aperture bounds follow the configuration on their own
    talc_mul u_mul_sx2 (.i_clk(i_clk), .i_en(1'b1),
        .i_a(talc_pkg::MUL_W'(w_sx)), .i_b(talc_pkg::MUL_W'(w_sx)), .o_p(w_sx2));
    talc_mul u_mul_sy2 (.i_clk(i_clk), .i_en(1'b1),
        .i_a(talc_pkg::MUL_W'(w_sy)), .i_b(talc_pkg::MUL_W'(w_sy)), .o_p(w_sy2));
    talc_mul u_mul_c (.i_clk(i_clk), .i_en(1'b1),
        .i_a(talc_pkg::MUL_W'(w_sx)), .i_b(talc_pkg::MUL_W'(w_sy)), .o_p(w_c_p));
    talc_mul u_mul_c2 (.i_clk(i_clk), .i_en(1'b1),
        .i_a(w_c_p[talc_pkg::MUL_W-1:0]), .i_b(w_c_p[talc_pkg::MUL_W-1:0]), .o_p(w_c2));

    // Hyperbola sums, then ellipse sum
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hsum <= talc_pkg::CMP_W'(w_xx) + talc_pkg::CMP_W'(w_yy);
            r_hxy2 <= talc_pkg::CMP_W'(w_xy) << 1;
            r_esum <= talc_pkg::CMP_W'(w_aa) + talc_pkg::CMP_W'(w_bb);
        end
    end

    assign w_hyp = (r_hxy2 > (talc_pkg::CMP_W'(w_sx2) << 32))
                || (r_hsum > (talc_pkg::CMP_W'(w_sy2) << 32));
    assign w_ell = r_esum > (talc_pkg::CMP_W'(w_c2) << 32);

    // Tag line: shift the word's classification, drop in test results
    always_comb begin
        n_tag[1].mom     = i_item.mom;
        n_tag[1].ap_en   = i_item.ap_en;
        n_tag[1].run     = i_item.run;
        n_tag[1].rect    = 1'b0;
        n_tag[1].hyp     = 1'b0;
        n_tag[1].element = i_item.element;
        n_tag[1].turn    = i_item.turn;
        for (int k = 2; k <= NST; k++) begin
            n_tag[k] = r_tag[k-1];
            if (k == ST_RECT) begin
                n_tag[k].rect = w_rect;
            end
            if (k == ST_HYP) begin
                n_tag[k].hyp = w_hyp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tag <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[NST-1:1], !i_empty};
            r_out_vld <= r_vld[NST];
        end
    end

    // Select the test of the configured shape
    always_comb begin
        case (i_cfg.shape_mode)
            talc_pkg::SHAPE_ELLIPSE: w_outside = w_ell;
            talc_pkg::SHAPE_HYPER:   w_outside = r_tag[NST].hyp;
            default:                 w_outside = r_tag[NST].rect;
        endcase
    end

    // Decide the loss code in priority order
    always_comb begin
        if (r_tag[NST].mom) begin
            n_out.status    = talc_pkg::ST_NEG_MOM;
            n_out.loss_kind = talc_pkg::KIND_LOSS;
        end else if (r_tag[NST].ap_en && w_outside) begin
            n_out.status    = talc_pkg::ST_APERTURE;
            n_out.loss_kind = talc_pkg::KIND_LOSS;
        end else if (r_tag[NST].run) begin
            n_out.status    = talc_pkg::ST_RUNAWAY;
            n_out.loss_kind = talc_pkg::KIND_RUNAWAY;
        end else begin
            n_out.status    = talc_pkg::ST_SURVIVED;
            n_out.loss_kind = talc_pkg::KIND_NONE;
        end
        if (n_out.loss_kind != talc_pkg::KIND_NONE) begin
            n_out.lost_element = 17'(r_tag[NST].element) + 17'd1;
            n_out.lost_turn    = r_tag[NST].turn;
        end else begin
            n_out.lost_element = '0;
            n_out.lost_turn    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/tilted_aperture_loss_check_core.sv -----
`timescale 1ns / 1ps
// Throughput: one word per cycle, set by the back pipeline of limb multipliers,
//   which holds as a whole only while its result register is full and stalled.
// Reset: synchronous, active low; clears handshake state, queue pointers and the
//   configuration registers to their reset values. No clearing pass.
// ----------------------------------------------------------------------------
// tilted_aperture_loss_check_core: particle loss check against a tilted aperture
// Configuration registers, front classifier, queue and exact aperture pipeline.
// ----------------------------------------------------------------------------
module tilted_aperture_loss_check_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  talc_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output talc_pkg::t_out                   o_out,
    input  logic                             i_cfg_we,
    input  logic [talc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [talc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    talc_pkg::t_cfg  r_cfg;
    talc_pkg::t_item w_front_item;
    talc_pkg::t_item w_q_item;
    logic            w_push;
    logic            w_pop;
    logic            w_q_full;
    logic            w_q_empty;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_size_x        <= '0;
            r_cfg.half_size_y        <= '0;
            r_cfg.shape_mode         <= talc_pkg::SHAPE_RECT;
            r_cfg.offset_x           <= '0;
            r_cfg.offset_y           <= '0;
            r_cfg.tilt_cosine        <= talc_pkg::TILT_COS_RESET;
            r_cfg.tilt_sine          <= '0;
            r_cfg.reference_momentum <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                talc_pkg::CFG_HALF_X:   r_cfg.half_size_x <= i_cfg_data;
                talc_pkg::CFG_HALF_Y:   r_cfg.half_size_y <= i_cfg_data;
                talc_pkg::CFG_SHAPE:    r_cfg.shape_mode  <= i_cfg_data[1:0];
                talc_pkg::CFG_OFFSET_X: r_cfg.offset_x    <= i_cfg_data;
                talc_pkg::CFG_OFFSET_Y: r_cfg.offset_y    <= i_cfg_data;
                talc_pkg::CFG_TILT_COS: r_cfg.tilt_cosine <= i_cfg_data[talc_pkg::TRIG_W-1:0];
                talc_pkg::CFG_TILT_SIN: r_cfg.tilt_sine   <= i_cfg_data[talc_pkg::TRIG_W-1:0];
                talc_pkg::CFG_REF_MOM:  r_cfg.reference_momentum <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: accept and classify
    talc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_full     (w_q_full),
        .o_push     (w_push),
        .o_item     (w_front_item)
    );

    // Queue between front and back
    talc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // Back: aperture tests and result
    talc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (w_q_item),
        .i_empty     (w_q_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

`ifndef ASSERT_OFF
    a_lost_element: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.loss_kind == talc_pkg::KIND_NONE)
                         == (o_out.lost_element == '0)))
        else $error("lost element does not match loss kind");

    a_runaway_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.status == talc_pkg::ST_RUNAWAY)
                         == (o_out.loss_kind == talc_pkg::KIND_RUNAWAY)))
        else $error("runaway status and loss kind disagree");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_q_full)
        else $error("input stalled while queue has room");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_full && !w_pop) |=> w_q_full)
        else $error("full queue changed without a pop");
`endif

endmodule

// ----- tb/tilted_aperture_loss_check_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilted_aperture_loss_check_core_tb: self-checking bench for the loss check
// Streams particle words through the core under several aperture settings and
// checks every result word against a bit-exact wide-integer predictor.
// ----------------------------------------------------------------------------
module tilted_aperture_loss_check_core_tb;

    import talc_pkg::*;

    localparam int QUIET_LIMIT = 3000;      // cycles with no word moving
    localparam int DRAIN_WAIT  = 16;        // latency margin after the last result
    localparam int LONG_HOLD   = 300;       // long receiver hold-off
    localparam int PHASE_ITEMS = 106;

    localparam logic signed [255:0] RUN_EDGE = 256'sd65536000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in                    i_in = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out                   o_out;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Aperture settings as the core should hold them
    logic signed [31:0]        ap_half_x = '0;
    logic signed [31:0]        ap_half_y = '0;
    logic [1:0]                ap_shape  = SHAPE_RECT;
    logic signed [31:0]        ap_off_x  = '0;
    logic signed [31:0]        ap_off_y  = '0;
    logic signed [TRIG_W-1:0]  tilt_cos  = TILT_COS_RESET;
    logic signed [TRIG_W-1:0]  tilt_sin  = '0;
    logic [31:0]               ref_mom   = '0;

    t_in         pending_particles[$];
    t_out        expected_losses[$];
    int unsigned pos_span = 32'd1 << 22;
    int          idle_odds = 0;
    bit          long_hold_req = 1'b0;
    bit          in_taken = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          errors = 0;

    tilted_aperture_loss_check_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predict the loss verdict of one particle word
    function automatic t_out predict_loss(input t_in w);
        logic signed [255:0] dx, dy, c, s, xr, yr, axr, ayr;
        logic signed [255:0] sx, sy, xx, yy, sxx, syy, apx, apy;
        logic outside;
        t_out r;
        dx = w.pos_x;
        dy = w.pos_y;
        dx = dx - ap_off_x;
        dy = dy - ap_off_y;
        c = tilt_cos;
        s = tilt_sin;
        xr = dx * c + dy * s;
        yr = dy * c - dx * s;
        axr = (xr < 0) ? -xr : xr;
        ayr = (yr < 0) ? -yr : yr;
        sx = ap_half_x;
        sy = ap_half_y;
        xx = xr * xr;
        yy = yr * yr;
        sxx = sx * sx;
        syy = sy * sy;
        outside = 1'b0;
        if (ap_half_x > 0 && ap_half_y > 0) begin
            case (ap_shape)
                SHAPE_ELLIPSE: begin
                    outside = (xx * syy + yy * sxx) > ((sxx * syy) <<< 32);
                end
                SHAPE_HYPER: begin
                    outside = ((axr * ayr) <<< 1) > (sxx <<< 32) ||
                              (xx + yy) > (syy <<< 32);
                end
                // undefined code falls back to the rectangle
                default: begin
                    outside = axr > (sx <<< 16) || ayr > (sy <<< 16);
                end
            endcase
        end
        apx = w.pos_x;
        apy = w.pos_y;
        if (apx < 0) apx = -apx;
        if (apy < 0) apy = -apy;
        r = '0;
        if (ref_mom != 0 && w.momentum_dev < DP_NEG_ONE) begin
            r.status = ST_NEG_MOM;
            r.loss_kind = KIND_LOSS;
        end else if (outside) begin
            r.status = ST_APERTURE;
            r.loss_kind = KIND_LOSS;
        end else if (apx > RUN_EDGE || apy > RUN_EDGE) begin
            r.status = ST_RUNAWAY;
            r.loss_kind = KIND_RUNAWAY;
        end
        if (r.loss_kind != KIND_NONE) begin
            r.lost_element = {1'b0, w.element_index} + 17'd1;
            r.lost_turn = w.turn_number;
        end
        return r;
    endfunction

    // Pick a coordinate around an aperture center
    function automatic logic [31:0] near(input logic signed [31:0] ctr);
        longint d;
        d = longint'($urandom_range(2 * pos_span)) - longint'(pos_span);
        return 32'(longint'(ctr) + d);
    endfunction

    // Pick a coordinate just around the 1000 cm edge
    function automatic logic [31:0] runaway_pos();
        logic [31:0] base;
        base = $urandom_range(1) ? 32'd65536000 : -32'sd65536000;
        return base + 32'($urandom_range(6)) - 32'd3;
    endfunction

    function automatic logic [31:0] extreme_pos();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic t_in particle(input logic [31:0] px, input logic [31:0] py,
                                     input logic [31:0] dp);
        t_in w;
        w.pos_x = px;
        w.pos_y = py;
        w.momentum_dev = dp;
        w.element_index = 16'($urandom);
        w.turn_number = $urandom;
        return w;
    endfunction

    // Mostly particles near the aperture, with edges and noise mixed in
    function automatic t_in rand_particle();
        t_in w;
        w = particle(near(ap_off_x), near(ap_off_y),
                     32'($urandom_range(32'd33554432)) - 32'd16777216);
        case ($urandom_range(9))
            6: begin
                if ($urandom_range(1)) w.pos_x = runaway_pos();
                else w.pos_y = runaway_pos();
            end
            7: w.momentum_dev = 32'($urandom_range(6)) - 32'd16777219;
            8: begin
                w.pos_x = $urandom;
                w.pos_y = $urandom;
                w.momentum_dev = $urandom;
            end
            9: begin
                w.pos_x = extreme_pos();
                w.pos_y = extreme_pos();
                if ($urandom_range(1)) w.momentum_dev = extreme_pos();
            end
            default: ;
        endcase
        return w;
    endfunction

    // Drive one register write and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_HALF_X:   ap_half_x = data;
            CFG_HALF_Y:   ap_half_y = data;
            CFG_SHAPE:    ap_shape = data[1:0];
            CFG_OFFSET_X: ap_off_x = data;
            CFG_OFFSET_Y: ap_off_y = data;
            CFG_TILT_COS: tilt_cos = data[TRIG_W-1:0];
            CFG_TILT_SIN: tilt_sin = data[TRIG_W-1:0];
            default:      ref_mom = data;
        endcase
    endtask

    task automatic set_aperture(input logic [31:0] hx, input logic [31:0] hy,
                                input logic [31:0] shape, input logic [31:0] ox,
                                input logic [31:0] oy, input logic [31:0] c,
                                input logic [31:0] s, input logic [31:0] mom);
        longint m;
        write_reg(CFG_HALF_X, hx);
        write_reg(CFG_HALF_Y, hy);
        write_reg(CFG_SHAPE, shape);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_TILT_COS, c);
        write_reg(CFG_TILT_SIN, s);
        write_reg(CFG_REF_MOM, mom);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // scale random positions to the aperture so both verdicts show up
        if (ap_half_x > 0 && ap_half_y > 0) begin
            m = (ap_half_x > ap_half_y) ? ap_half_x : ap_half_y;
            pos_span = (m > (longint'(1) << 28)) ? (32'd1 << 30) : 32'(3 * m);
        end else begin
            pos_span = 32'd1 << 22;
        end
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) pending_particles.push_back(rand_particle());
    endtask

    // Hold the sender until every result is back, then let the pipe settle
    task automatic drain();
        while (pending_particles.size() != 0 || i_in_valid || expected_losses.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic check_loss(input t_out got);
        t_out want;
        want = expected_losses.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.loss_kind !== want.loss_kind) begin
            $error("loss_kind: expected %0d, actual %0d", want.loss_kind, got.loss_kind);
            errors++;
        end
        if (got.lost_element !== want.lost_element) begin
            $error("lost_element: expected %0d, actual %0d",
                   want.lost_element, got.lost_element);
            errors++;
        end
        if (got.lost_turn !== want.lost_turn) begin
            $error("lost_turn: expected %0d, actual %0d", want.lost_turn, got.lost_turn);
            errors++;
        end
    endtask

    // Sample both handshakes, predict on input, check on output
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                expected_losses.push_back(predict_loss(i_in));
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_losses.size() == 0) begin
                    $error("result word with no particle pending");
                    errors++;
                end else begin
                    check_loss(o_out);
                end
            end
            if (in_taken || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
    end

    // Offer particle words; hold a stalled word, insert random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            i_in_valid <= 1'b1;
        end else if (gap_left != 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
            gap_left = $urandom_range(14, 1) - 1;
            i_in_valid <= 1'b0;
        end else if (pending_particles.size() != 0) begin
            i_in <= pending_particles.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Stall the result side in bursts, once for a long stretch
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
            stall_left = $urandom_range(14, 1) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("tilted_aperture_loss_check_core test failed");
        $finish;
    end

    initial begin : stimulus
        t_in w;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: aperture off, momentum never negative
        idle_odds = 4;
        pending_particles.push_back(particle(32'd0, 32'd0, 32'd0));
        pending_particles.push_back(particle(32'd65536000, 32'd0, 32'd0));
        pending_particles.push_back(particle(32'd65536001, 32'd0, 32'd0));
        pending_particles.push_back(particle(32'd0, -32'sd65536000, 32'd0));
        pending_particles.push_back(particle(32'd0, -32'sd65536001, 32'd0));
        pending_particles.push_back(particle(32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
        pending_particles.push_back(particle(32'd0, 32'd0, 32'h8000_0000));
        add_random(PHASE_ITEMS);
        drain();

        // Untilted rectangle, half-sizes 1 cm x 2 cm: edges, momentum floor, priority
        set_aperture(32'd65536, 32'd131072, SHAPE_RECT, 32'd0, 32'd0,
                     32'd65536, 32'd0, 32'd1);
        idle_odds = 0;
        pending_particles.push_back(particle(32'd65536, 32'd0, 32'd0));
        pending_particles.push_back(particle(32'd65537, 32'd0, 32'd0));
        pending_particles.push_back(particle(-32'sd65537, 32'd0, 32'd0));
        pending_particles.push_back(particle(32'd0, 32'd131072, 32'd0));
        pending_particles.push_back(particle(32'd0, -32'sd131073, 32'd0));
        pending_particles.push_back(particle(32'd0, 32'd0, -32'sd16777216));
        pending_particles.push_back(particle(32'd0, 32'd0, -32'sd16777217));
        pending_particles.push_back(particle(32'd0, 32'd0, 32'h8000_0000));
        pending_particles.push_back(particle(32'd0, 32'd0, 32'h7FFF_FFFF));
        pending_particles.push_back(particle(32'h7FFF_FFFF, 32'd0, 32'h8000_0000));
        pending_particles.push_back(particle(32'h7FFF_FFFF, 32'd0, 32'd0));
        w = particle(32'd70000, 32'd0, 32'd0);
        w.element_index = 16'hFFFF;
        w.turn_number = 32'hFFFF_FFFF;
        pending_particles.push_back(w);
        add_random(PHASE_ITEMS);
        drain();

        // Offset ellipse tilted by 30 degrees; fill the core behind a long hold
        set_aperture(32'd327680, 32'd196608, SHAPE_ELLIPSE, 32'd65536, -32'sd131072,
                     32'd56756, 32'd32768, $urandom_range(32'hFFFF_FFFF, 1));
        idle_odds = 8;
        add_random(PHASE_ITEMS);
        long_hold_req = 1'b1;
        drain();

        // Hyperbola tilted by -45 degrees, largest reference momentum
        set_aperture(32'd131072, 32'd262144, SHAPE_HYPER, 32'($urandom_range(65536)),
                     -32'sd32768, 32'd46341, -32'sd46341, 32'hFFFF_FFFF);
        idle_odds = 3;
        add_random(PHASE_ITEMS);
        drain();

        // Undefined shape code with an unnormalized tilt
        set_aperture($urandom_range(32'h0010_0000, 1), $urandom_range(32'h0010_0000, 1),
                     32'd3, 32'd0, 32'd0, -32'sd65536, 32'd65536, 32'd0);
        idle_odds = 16;
        add_random(PHASE_ITEMS);
        drain();

        // Extremes: largest half-sizes, extreme offsets, 18-bit tilt limits
        set_aperture(32'h7FFF_FFFF, 32'h7FFF_FFFF, SHAPE_ELLIPSE, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h0002_0000, 32'h0001_FFFF, 32'd1);
        idle_odds = 5;
        add_random(PHASE_ITEMS);
        drain();

        // Negative half-size turns the aperture test off
        set_aperture(-32'sd327680, 32'd65536, SHAPE_RECT, 32'd0, 32'd0,
                     32'd65536, 32'd0, 32'd7);
        idle_odds = 0;
        add_random(PHASE_ITEMS);
        drain();

        // Fully random register contents, upper bits of narrow registers too
        set_aperture($urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
        idle_odds = 6;
        add_random(PHASE_ITEMS);
        drain();

        // Closing stretch with no idling: randomly tilted hyperbola
        set_aperture($urandom_range(32'h0040_0000, 32'h0000_4000),
                     $urandom_range(32'h0040_0000, 32'h0000_4000), SHAPE_HYPER,
                     32'($urandom_range(32'h0008_0000)), 32'($urandom_range(32'h0008_0000)),
                     $urandom, $urandom, $urandom);
        idle_odds = 0;
        add_random(PHASE_ITEMS);
        drain();

        if (errors == 0 && expected_losses.size() == 0) begin
            $display("tilted_aperture_loss_check_core test passed");
        end else begin
            $display("tilted_aperture_loss_check_core test failed");
        end
        $finish;
    end

endmodule
